// ===== design/dcem_pkg.sv =====
// shared types, constants and register codes of the depth cross erosion mask
package dcem_pkg;

    localparam int MAX_WIDTH_DEF  = 512;
    localparam int MAX_HEIGHT_DEF = 512;

    localparam int DIM_W   = 10;
    localparam int REACH_W = 7;
    localparam int DEPTH_W = 16;
    localparam int THR_W   = 12;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    localparam logic [1:0] REG_WIDTH      = 2'd0;
    localparam logic [1:0] REG_HEIGHT     = 2'd1;
    localparam logic [1:0] REG_MIN_HEIGHT = 2'd2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EMIT = 1'b1;

    localparam int FLAG_LOW_BIT = 0;
    localparam int FLAG_NZ_BIT  = 1;

    localparam logic [DIM_W-1:0] WIDTH_RST      = 10'd512;
    localparam logic [DIM_W-1:0] HEIGHT_RST     = 10'd512;
    localparam logic [THR_W-1:0] MIN_HEIGHT_RST = 12'd2000;

    // x/10 == (x*205)>>11 for every 10-bit x
    localparam logic [7:0] DIV10_MUL   = 8'd205;
    localparam int         DIV10_SHIFT = 11;

    typedef struct packed {
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [REACH_W-1:0] reach_c;
        logic [REACH_W-1:0] reach_r;
    } geom_t;

    typedef struct packed {
        logic             cmd;
        logic [1:0]       flags;
        logic [DIM_W-1:0] row;
        logic [DIM_W-1:0] col;
        logic             last;
    } entry_t;

endpackage

// ===== design/dcem_queue.sv =====
// short item queue between the front and the back
module dcem_queue
    import dcem_pkg::*;
#(
    parameter int ADDR_W = 18
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  entry_t            push_entry,
    input  logic [ADDR_W-1:0] push_addr,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output entry_t            pop_entry,
    output logic [ADDR_W-1:0] pop_addr
);

    entry_t            entry_reg [QDEPTH];
    logic [ADDR_W-1:0] addr_reg  [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign empty     = (count_reg == '0);
    assign do_push   = push & ~full;
    assign do_pop    = pop & ~empty;
    assign pop_entry = entry_reg[rd_ptr_reg];
    assign pop_addr  = addr_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
            addr_reg[wr_ptr_reg]  <= push_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue pushed while full");
`endif

endmodule

// ===== design/dcem_front.sv =====
// front: config registers, frame geometry, item classification and position counters
module dcem_front
    import dcem_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    parameter int ADDR_W     = 18
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               push,
    output logic               full,
    input  logic               command,
    input  logic [DEPTH_W-1:0] depth,
    input  logic               q_full,
    output logic               q_push,
    output entry_t             q_entry,
    output logic [ADDR_W-1:0]  q_addr,
    output geom_t              geom
);

    localparam int SIZE_W = ADDR_W + 1;
    localparam int CNT_W  = $clog2(ADDR_W + 1);
    localparam logic [12:0] MAXW13 = 13'(MAX_WIDTH);
    localparam logic [12:0] MAXH13 = 13'(MAX_HEIGHT);

    typedef enum logic [2:0] {
        F_RUN    = 3'b001,
        F_SETTLE = 3'b010,
        F_DIV    = 3'b100
    } fstate_t;

    fstate_t            fstate_reg, fstate_next;
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    logic [THR_W-1:0]   min_height_reg;
    geom_t              geom_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [ADDR_W-1:0]  load_pos_reg, load_pos_next;
    logic [ADDR_W-1:0]  emit_pos_reg, emit_pos_next;
    logic [DIM_W-1:0]   row_reg, row_next;
    logic [DIM_W-1:0]   col_reg, col_next;
    logic [CNT_W-1:0]   div_cnt_reg, div_cnt_next;
    logic [DIM_W-1:0]   div_rem_reg, div_rem_next;
    logic [ADDR_W-1:0]  div_quo_reg, div_quo_next;
    logic [ADDR_W-1:0]  div_num_reg, div_num_next;

    logic                 cfg_wr;
    logic [1:0]           cfg_idx;
    logic [DIM_W-1:0]     eff_w, eff_h;
    logic [17:0]          prod_c, prod_r;
    logic [2*DIM_W-1:0]   size_full;
    logic                 acc;
    logic                 emit_last;
    logic [SIZE_W-1:0]    load_inc, emit_inc;
    logic [DIM_W:0]       rem_sh, rem_sub;
    logic                 rem_ge;
    logic [ADDR_W-1:0]    quo_new;

    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[3:2];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= WIDTH_RST;
            height_reg     <= HEIGHT_RST;
            min_height_reg <= MIN_HEIGHT_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_WIDTH:      width_reg      <= pwdata[DIM_W-1:0];
                REG_HEIGHT:     height_reg     <= pwdata[DIM_W-1:0];
                REG_MIN_HEIGHT: min_height_reg <= pwdata[THR_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_WIDTH:      prdata = PDATA_W'(width_reg);
            REG_HEIGHT:     prdata = PDATA_W'(height_reg);
            REG_MIN_HEIGHT: prdata = PDATA_W'(min_height_reg);
            default:        prdata = '0;
        endcase
    end

    // effective frame size, reaches and pixel count
    always_comb
    begin
        if (width_reg == '0)
        begin
            eff_w = DIM_W'(1);
        end
        else if ({3'b000, width_reg} > MAXW13)
        begin
            eff_w = MAXW13[DIM_W-1:0];
        end
        else
        begin
            eff_w = width_reg;
        end
        if (height_reg == '0)
        begin
            eff_h = DIM_W'(1);
        end
        else if ({3'b000, height_reg} > MAXH13)
        begin
            eff_h = MAXH13[DIM_W-1:0];
        end
        else
        begin
            eff_h = height_reg;
        end
        prod_c    = 18'(eff_w) * 18'(DIV10_MUL);
        prod_r    = 18'(eff_h) * 18'(DIV10_MUL);
        size_full = (2*DIM_W)'(eff_w) * (2*DIM_W)'(eff_h);
    end

    always_ff @(posedge clk)
    begin
        geom_reg.width   <= eff_w;
        geom_reg.height  <= eff_h;
        geom_reg.reach_c <= prod_c[DIV10_SHIFT +: REACH_W];
        geom_reg.reach_r <= prod_r[DIV10_SHIFT +: REACH_W];
        size_reg         <= SIZE_W'(size_full);
    end

    assign geom = geom_reg;

    // item classification
    assign full      = (fstate_reg != F_RUN) | q_full;
    assign acc       = push & ~full;
    assign q_push    = acc;
    assign load_inc  = {1'b0, load_pos_reg} + 1'b1;
    assign emit_inc  = {1'b0, emit_pos_reg} + 1'b1;
    assign emit_last = (emit_inc == size_reg);

    always_comb
    begin
        q_entry.cmd                 = command;
        q_entry.flags[FLAG_LOW_BIT] = (depth <= DEPTH_W'(min_height_reg));
        q_entry.flags[FLAG_NZ_BIT]  = (depth != '0);
        q_entry.row                 = row_reg;
        q_entry.col                 = col_reg;
        q_entry.last                = emit_last;
        q_addr = (command == CMD_EMIT) ? emit_pos_reg : load_pos_reg;
    end

    // one restoring division step per cycle: emit position over frame width
    assign rem_sh  = {div_rem_reg, div_num_reg[ADDR_W-1]};
    assign rem_ge  = (rem_sh >= {1'b0, geom_reg.width});
    assign rem_sub = rem_ge ? (rem_sh - {1'b0, geom_reg.width}) : rem_sh;
    assign quo_new = {div_quo_reg[ADDR_W-2:0], rem_ge};

    always_comb
    begin
        fstate_next   = fstate_reg;
        load_pos_next = load_pos_reg;
        emit_pos_next = emit_pos_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        div_cnt_next  = div_cnt_reg;
        div_rem_next  = div_rem_reg;
        div_quo_next  = div_quo_reg;
        div_num_next  = div_num_reg;
        case (fstate_reg)
            F_RUN:
            begin
                if (acc && command == CMD_LOAD)
                begin
                    load_pos_next = (load_inc >= size_reg) ? '0 : load_inc[ADDR_W-1:0];
                end
                if (acc && command == CMD_EMIT)
                begin
                    if (emit_last)
                    begin
                        emit_pos_next = '0;
                        row_next      = '0;
                        col_next      = '0;
                    end
                    else
                    begin
                        emit_pos_next = emit_inc[ADDR_W-1:0];
                        if (col_reg + 1'b1 == geom_reg.width)
                        begin
                            col_next = '0;
                            row_next = row_reg + 1'b1;
                        end
                        else
                        begin
                            col_next = col_reg + 1'b1;
                        end
                    end
                end
            end
            F_SETTLE:
            begin
                div_cnt_next = CNT_W'(ADDR_W);
                div_rem_next = '0;
                div_quo_next = '0;
                div_num_next = emit_pos_reg;
                fstate_next  = F_DIV;
            end
            F_DIV:
            begin
                div_rem_next = rem_sub[DIM_W-1:0];
                div_quo_next = quo_new;
                div_num_next = {div_num_reg[ADDR_W-2:0], 1'b0};
                div_cnt_next = div_cnt_reg - 1'b1;
                if (div_cnt_reg == CNT_W'(1))
                begin
                    // positions past the new frame restart at the origin
                    if ({1'b0, emit_pos_reg} >= size_reg)
                    begin
                        emit_pos_next = '0;
                        row_next      = '0;
                        col_next      = '0;
                    end
                    else
                    begin
                        row_next = DIM_W'(quo_new);
                        col_next = rem_sub[DIM_W-1:0];
                    end
                    if ({1'b0, load_pos_reg} >= size_reg)
                    begin
                        load_pos_next = '0;
                    end
                    fstate_next = F_RUN;
                end
            end
            default:
            begin
                fstate_next = F_SETTLE;
            end
        endcase
        if (cfg_wr && (cfg_idx == REG_WIDTH || cfg_idx == REG_HEIGHT))
        begin
            fstate_next = F_SETTLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fstate_reg   <= F_SETTLE;
            load_pos_reg <= '0;
            emit_pos_reg <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            div_cnt_reg  <= '0;
        end
        else
        begin
            fstate_reg   <= fstate_next;
            load_pos_reg <= load_pos_next;
            emit_pos_reg <= emit_pos_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            div_cnt_reg  <= div_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_rem_reg <= div_rem_next;
        div_quo_reg <= div_quo_next;
        div_num_reg <= div_num_next;
    end

`ifndef SYNTHESIS
    a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (fstate_reg == F_RUN) |-> (col_reg < geom_reg.width
            && {1'b0, emit_pos_reg} < size_reg && {1'b0, load_pos_reg} < size_reg))
        else $error("position counters outside the frame");
    a_no_push_in_resync: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (fstate_reg == F_RUN && !q_full))
        else $error("item queued while positions resync");
`endif

endmodule

// ===== design/dcem_back.sv =====
// back: flag store, cross neighbourhood scan and result register
module dcem_back
    import dcem_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    parameter int ADDR_W     = 18
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  geom_t             geom,
    input  logic              q_empty,
    input  entry_t            q_entry,
    input  logic [ADDR_W-1:0] q_addr,
    output logic              q_pop,
    input  logic              pop,
    output logic              empty,
    output logic              mask,
    output logic              last_pixel
);

    localparam int STORE = MAX_WIDTH * MAX_HEIGHT;

    typedef enum logic [5:0] {
        B_IDLE  = 6'b000001,
        B_RIGHT = 6'b000010,
        B_LEFT  = 6'b000100,
        B_UP    = 6'b001000,
        B_DOWN  = 6'b010000,
        B_DONE  = 6'b100000
    } bstate_t;

    logic [1:0]         mem [STORE];

    bstate_t            bstate_reg, bstate_next;
    logic [REACH_W-1:0] k_reg, k_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [ADDR_W-1:0]  base_reg, base_next;
    logic [DIM_W-1:0]   row_reg, row_next;
    logic [DIM_W-1:0]   col_reg, col_next;
    logic               item_last_reg, item_last_next;
    logic               acc_nz_reg, acc_low_reg;
    logic               rd_valid_reg, rd_center_reg;
    logic [1:0]         rd_data_reg;
    logic               out_valid_reg, out_mask_reg, out_last_reg;

    logic               we, re, re_center, start, done_fire;
    logic [ADDR_W-1:0]  raddr;
    logic [ADDR_W-1:0]  w_a;
    logic [DIM_W-1:0]   kx;
    logic               cond;
    logic               center_counts;

    assign w_a   = ADDR_W'(geom.width);
    assign kx    = DIM_W'(k_reg);
    assign q_pop = (bstate_reg == B_IDLE) & ~q_empty;
    assign we    = q_pop & (q_entry.cmd == CMD_LOAD);
    assign start = q_pop & (q_entry.cmd == CMD_EMIT);
    assign center_counts = (geom.reach_c != '0) | (geom.reach_r != '0);
    assign done_fire = (bstate_reg == B_DONE) & (~out_valid_reg | pop);

    always_comb
    begin
        case (bstate_reg)
            B_RIGHT: cond = (k_reg < geom.reach_c)
                         && ({1'b0, col_reg} + {1'b0, kx} < {1'b0, geom.width});
            B_LEFT:  cond = (k_reg < geom.reach_c) && (kx <= col_reg);
            B_UP:    cond = (k_reg < geom.reach_r) && (kx <= row_reg);
            B_DOWN:  cond = (k_reg < geom.reach_r)
                         && ({1'b0, row_reg} + {1'b0, kx} < {1'b0, geom.height});
            default: cond = 1'b0;
        endcase
    end

    always_comb
    begin
        bstate_next    = bstate_reg;
        k_next         = k_reg;
        addr_next      = addr_reg;
        base_next      = base_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        item_last_next = item_last_reg;
        re             = 1'b0;
        re_center      = 1'b0;
        raddr          = addr_reg;
        case (bstate_reg)
            B_IDLE:
            begin
                if (start)
                begin
                    re             = 1'b1;
                    re_center      = 1'b1;
                    raddr          = q_addr;
                    base_next      = q_addr;
                    row_next       = q_entry.row;
                    col_next       = q_entry.col;
                    item_last_next = q_entry.last;
                    k_next         = REACH_W'(1);
                    addr_next      = q_addr + 1'b1;
                    bstate_next    = B_RIGHT;
                end
            end
            B_RIGHT, B_LEFT, B_UP, B_DOWN:
            begin
                if (cond)
                begin
                    re     = 1'b1;
                    k_next = k_reg + 1'b1;
                    case (bstate_reg)
                        B_RIGHT: addr_next = addr_reg + 1'b1;
                        B_LEFT:  addr_next = addr_reg - 1'b1;
                        B_UP:    addr_next = addr_reg - w_a;
                        default: addr_next = addr_reg + w_a;
                    endcase
                end
                else
                begin
                    k_next = REACH_W'(1);
                    case (bstate_reg)
                        B_RIGHT:
                        begin
                            addr_next   = base_reg - 1'b1;
                            bstate_next = B_LEFT;
                        end
                        B_LEFT:
                        begin
                            addr_next   = base_reg - w_a;
                            bstate_next = B_UP;
                        end
                        B_UP:
                        begin
                            addr_next   = base_reg + w_a;
                            bstate_next = B_DOWN;
                        end
                        default:
                        begin
                            bstate_next = B_DONE;
                        end
                    endcase
                end
            end
            B_DONE:
            begin
                if (done_fire)
                begin
                    bstate_next = B_IDLE;
                end
            end
            default:
            begin
                bstate_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[q_addr] <= q_entry.flags;
        end
        if (re)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg         <= k_next;
        addr_reg      <= addr_next;
        base_reg      <= base_next;
        row_reg       <= row_next;
        col_reg       <= col_next;
        item_last_reg <= item_last_next;
        if (done_fire)
        begin
            out_mask_reg <= acc_nz_reg & ~acc_low_reg;
            out_last_reg <= item_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bstate_reg    <= B_IDLE;
            rd_valid_reg  <= 1'b0;
            rd_center_reg <= 1'b0;
            acc_nz_reg    <= 1'b0;
            acc_low_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            bstate_reg    <= bstate_next;
            rd_valid_reg  <= re;
            rd_center_reg <= re_center;
            if (start)
            begin
                acc_nz_reg  <= 1'b0;
                acc_low_reg <= 1'b0;
            end
            else if (rd_valid_reg)
            begin
                // the pixel itself only counts as a neighbour when some reach is nonzero
                if (rd_center_reg)
                begin
                    acc_nz_reg  <= rd_data_reg[FLAG_NZ_BIT];
                    acc_low_reg <= acc_low_reg | (rd_data_reg[FLAG_LOW_BIT] & center_counts);
                end
                else
                begin
                    acc_low_reg <= acc_low_reg | rd_data_reg[FLAG_LOW_BIT];
                end
            end
            if (done_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign empty      = ~out_valid_reg;
    assign mask       = out_mask_reg;
    assign last_pixel = out_last_reg;

`ifndef SYNTHESIS
    a_reads_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (bstate_reg == B_DONE) |-> !rd_valid_reg)
        else $error("result formed with a read still in flight");
    a_result_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (bstate_reg == B_DONE && out_valid_reg && !pop) |=> (bstate_reg == B_DONE))
        else $error("result dropped while output slot busy");
    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        done_fire |=> (out_valid_reg && bstate_reg == B_IDLE))
        else $error("finished item did not reach the output register");
`endif

endmodule

// ===== design/depth_cross_erosion_mask.sv =====
// top level of the depth cross erosion mask: front, item queue and back
//
//  channel   direction  handshake               payload
//  config    in/out     psel penable pwrite     paddr pwdata prdata
//  items     in         push / full             command depth
//  results   out        pop / empty             mask last_pixel
//
// a load item is written into the flag store as it is popped; an emit item scans a cross
// whose arms grow with width/10 and height/10 and shorten near the frame edges, through
// the single read port of the flag store (one flag read per cycle); after reset, and
// after each write of frame_width or frame_height, full stays high while the emit
// row and column are recomputed
// the four-entry queue takes items while the back scans or a result waits
module depth_cross_erosion_mask
    import dcem_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               push,
    output logic               full,
    input  logic               command,
    input  logic [DEPTH_W-1:0] depth,
    output logic               empty,
    input  logic               pop,
    output logic               mask,
    output logic               last_pixel
);

    localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT);

    geom_t             geom;
    logic              q_full, q_push, q_empty, q_pop;
    entry_t            f_entry, b_entry;
    logic [ADDR_W-1:0] f_addr, b_addr;

    dcem_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .ADDR_W     (ADDR_W)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .push    (push),
        .full    (full),
        .command (command),
        .depth   (depth),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (f_entry),
        .q_addr  (f_addr),
        .geom    (geom)
    );

    dcem_queue #(
        .ADDR_W (ADDR_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (f_entry),
        .push_addr  (f_addr),
        .full       (q_full),
        .pop        (q_pop),
        .empty      (q_empty),
        .pop_entry  (b_entry),
        .pop_addr   (b_addr)
    );

    dcem_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .ADDR_W     (ADDR_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .geom       (geom),
        .q_empty    (q_empty),
        .q_entry    (b_entry),
        .q_addr     (b_addr),
        .q_pop      (q_pop),
        .pop        (pop),
        .empty      (empty),
        .mask       (mask),
        .last_pixel (last_pixel)
    );

endmodule

// ===== test/depth_cross_erosion_mask_test.sv =====
// testbench of the depth cross erosion mask: directed and random items checked against a predictor
module depth_cross_erosion_mask_test
    import dcem_pkg::*;
();

    localparam int STORE_SIZE   = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 32;
    localparam int TAIL_CYCLES  = 64;
    localparam int ITEM_TARGET  = 1900;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct {
        bit mask_bit;
        bit last_bit;
    } mask_result_t;

    // mirror of the flag store, the raster positions and the registers
    class erosion_board;
        bit [1:0]       flags [STORE_SIZE];
        bit             written [STORE_SIZE];
        int unsigned    load_pos;
        int unsigned    emit_pos;
        bit [DIM_W-1:0] width_reg;
        bit [DIM_W-1:0] height_reg;
        bit [THR_W-1:0] min_reg;
        mask_result_t   pending_masks [$];
        int unsigned    errors;

        function new();
            load_pos   = 0;
            emit_pos   = 0;
            width_reg  = WIDTH_RST;
            height_reg = HEIGHT_RST;
            min_reg    = MIN_HEIGHT_RST;
            errors     = 0;
        endfunction

        function int unsigned span(bit [DIM_W-1:0] v, int unsigned lim);
            if (v == 0)
                return 1;
            if (v > lim)
                return lim;
            return v;
        endfunction

        function int unsigned cur_w();
            return span(width_reg, MAX_WIDTH_DEF);
        endfunction

        function int unsigned cur_h();
            return span(height_reg, MAX_HEIGHT_DEF);
        endfunction

        function void set_reg(logic [1:0] idx, logic [PDATA_W-1:0] value);
            case (idx)
                REG_WIDTH:      width_reg  = value[DIM_W-1:0];
                REG_HEIGHT:     height_reg = value[DIM_W-1:0];
                REG_MIN_HEIGHT: min_reg    = value[THR_W-1:0];
                default: ;
            endcase
        endfunction

        // walks the cross around p: with probe set, asks whether p and every entry
        // of the cross were loaded; otherwise whether no entry of the cross is too low
        function bit cross_clear(int unsigned p, int unsigned w, int unsigned h, bit probe);
            int unsigned row;
            int unsigned col;
            int unsigned idx [$];
            row = p / w;
            col = p % w;
            for (int unsigned k = 0; k < w / 10; k++)
            begin
                if (col + k < w)
                    idx.push_back(row * w + col + k);
                if (k <= col)
                    idx.push_back(row * w + col - k);
            end
            for (int unsigned k = 0; k < h / 10; k++)
            begin
                if (k <= row)
                    idx.push_back((row - k) * w + col);
                if (row + k < h)
                    idx.push_back((row + k) * w + col);
            end
            if (probe)
                idx.push_back(p);
            foreach (idx[i])
            begin
                if (probe ? !written[idx[i]] : flags[idx[i]][FLAG_LOW_BIT])
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        // an emit is only allowed once its whole cross has been loaded since reset
        function bit emit_ready();
            int unsigned w;
            int unsigned h;
            w = cur_w();
            h = cur_h();
            return cross_clear((emit_pos >= w * h) ? 0 : emit_pos, w, h, 1'b1);
        endfunction

        function void note_item(logic cmd, logic [DEPTH_W-1:0] d);
            int unsigned  w;
            int unsigned  h;
            int unsigned  size;
            mask_result_t r;
            w = cur_w();
            h = cur_h();
            size = w * h;
            if (cmd == CMD_LOAD)
            begin
                if (load_pos >= size)
                    load_pos = 0;
                flags[load_pos][FLAG_LOW_BIT] = (d <= min_reg);
                flags[load_pos][FLAG_NZ_BIT]  = (d != 0);
                written[load_pos] = 1'b1;
                load_pos = (load_pos + 1 >= size) ? 0 : load_pos + 1;
            end
            else
            begin
                if (emit_pos >= size)
                    emit_pos = 0;
                r.mask_bit = flags[emit_pos][FLAG_NZ_BIT] && cross_clear(emit_pos, w, h, 1'b0);
                r.last_bit = (emit_pos + 1 == size);
                pending_masks.push_back(r);
                emit_pos = (emit_pos + 1 >= size) ? 0 : emit_pos + 1;
            end
        endfunction

        task report(string msg);
            $display("%0t mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic m, logic lp);
            mask_result_t e;
            if (pending_masks.size() == 0)
            begin
                report($sformatf("mask=%b last_pixel=%b with no emit waiting", m, lp));
                return;
            end
            e = pending_masks.pop_front();
            if (m !== e.mask_bit)
                report($sformatf("mask %b, expected %b", m, e.mask_bit));
            if (lp !== e.last_bit)
                report($sformatf("last_pixel %b, expected %b", lp, e.last_bit));
        endtask
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               push = 1'b0;
    logic               full;
    logic               command = CMD_LOAD;
    logic [DEPTH_W-1:0] depth = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic               mask;
    logic               last_pixel;

    erosion_board board = new();
    int unsigned  items_sent = 0;
    int unsigned  burst_left = 0;
    int unsigned  stall_left = 0;
    int unsigned  stall_max = 0;
    int unsigned  mode_cycles = 0;
    int unsigned  quiet_cycles = 0;

    logic [DEPTH_W-1:0] probe_depths [12] = '{16'd0, 16'd1, 16'd1999, 16'd2000, 16'd2001,
        16'hFFFF, 16'h8000, 16'd4095, 16'h5555, 16'hAAAA, 16'd2000, 16'd3000};

    depth_cross_erosion_mask dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .push       (push),
        .full       (full),
        .command    (command),
        .depth      (depth),
        .empty      (empty),
        .pop        (pop),
        .mask       (mask),
        .last_pixel (last_pixel)
    );

    always #5 clk = ~clk;

    // receiver: pops with stalls whose length changes every so often
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
                board.check_result(mask, last_pixel);
            if (mode_cycles == 0)
            begin
                mode_cycles = $urandom_range(100, 400);
                case ($urandom_range(0, 2))
                    0: stall_max = 0;
                    1: stall_max = 3;
                    default: stall_max = 40;
                endcase
            end
            mode_cycles--;
            if (stall_left != 0)
            begin
                pop <= 1'b0;
                stall_left--;
            end
            else
            begin
                pop <= 1'b1;
                if (stall_max != 0 && $urandom_range(0, 2) == 0)
                    stall_left = $urandom_range(1, stall_max);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty) || (psel && penable))
                quiet_cycles <= 0;
            else if (quiet_cycles == IDLE_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // back-to-back writes keep psel high; the caller ends the transfer
    task automatic write_reg(logic [1:0] idx, logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        board.set_reg(idx, value);
    endtask

    // waits until the block is idle, then writes all registers; upper bits are noise
    task automatic configure(int unsigned w, int unsigned h, int unsigned thr);
        push <= 1'b0;
        while (board.pending_masks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        write_reg(REG_WIDTH, ($urandom() << DIM_W) | (w & 32'h3FF));
        write_reg(REG_UNUSED, $urandom());
        write_reg(REG_HEIGHT, ($urandom() << DIM_W) | (h & 32'h3FF));
        write_reg(REG_MIN_HEIGHT, ($urandom() << THR_W) | (thr & 32'hFFF));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_item(logic cmd, logic [DEPTH_W-1:0] d);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            if ($urandom_range(0, 39) == 0)
            begin
                // hold off until the results side has caught up
                push <= 1'b0;
                do @(posedge clk); while (board.pending_masks.size() != 0);
            end
            else if ($urandom_range(0, 3) != 0)
            begin
                push <= 1'b0;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
        push    <= 1'b1;
        command <= cmd;
        depth   <= d;
        do @(posedge clk); while (full);
        board.note_item(cmd, d);
        burst_left--;
        items_sent++;
    endtask

    function automatic logic [DEPTH_W-1:0] pick_depth(int unsigned thr, int unsigned low_pct);
        if ($urandom_range(0, 99) < low_pct)
        begin
            case ($urandom_range(0, 3))
                0: return '0;
                1: return DEPTH_W'(thr);
                default: return DEPTH_W'($urandom_range(0, thr));
            endcase
        end
        case ($urandom_range(0, 7))
            0: return DEPTH_W'(thr + 1);
            1: return '1;
            default: return DEPTH_W'($urandom_range(thr + 1, 65535));
        endcase
    endfunction

    task automatic run_phase(int unsigned w, int unsigned h, int unsigned thr,
                             int unsigned n, int unsigned low_pct);
        configure(w, h, thr);
        repeat (n)
        begin
            if (board.emit_ready() && $urandom_range(0, 1) == 1)
                send_item(CMD_EMIT, DEPTH_W'($urandom()));
            else
                send_item(CMD_LOAD, pick_depth(board.min_reg, low_pct));
        end
    endtask

    initial
    begin
        int unsigned w;
        int unsigned h;
        int unsigned thr;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // 4x3 frame, no reach: mask follows the nonzero bit, last pixel and wrap
        configure(4, 3, 2000);
        foreach (probe_depths[i])
            send_item(CMD_LOAD, probe_depths[i]);
        repeat (12) send_item(CMD_EMIT, DEPTH_W'($urandom()));

        // size and threshold extremes, zero and oversize values included
        run_phase(1, 512, 0, 250, 5);
        run_phase(512, 1, 4095, 250, 5);
        run_phase(1023, 0, 3000, 150, 2);
        run_phase(0, 1023, 2000, 150, 2);
        run_phase(0, 0, 1, 40, 30);

        while (items_sent < ITEM_TARGET)
        begin
            case ($urandom_range(0, 4))
                0:
                begin
                    w = $urandom_range(0, 1023);
                    h = $urandom_range(0, 3);
                end
                1:
                begin
                    w = $urandom_range(0, 3);
                    h = $urandom_range(0, 1023);
                end
                2:
                begin
                    // same geometry, so positions carry over
                    w = board.width_reg;
                    h = board.height_reg;
                end
                default:
                begin
                    w = $urandom_range(1, 30);
                    h = $urandom_range(1, 30);
                end
            endcase
            case ($urandom_range(0, 3))
                0: thr = $urandom_range(0, 4095);
                1: thr = board.min_reg;
                default: thr = $urandom_range(0, 3000);
            endcase
            run_phase(w, h, thr, $urandom_range(60, 160), $urandom_range(0, 30));
        end

        push <= 1'b0;
        while (board.pending_masks.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (board.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== depth_cross_erosion_mask.f =====
design/dcem_pkg.sv
design/dcem_queue.sv
design/dcem_front.sv
design/dcem_back.sv
design/depth_cross_erosion_mask.sv
test/depth_cross_erosion_mask_test.sv
